/* sv/lpe_pkg.sv */
// Shared types and constants for the LED pixel pulse code encoder.
// No dependencies; imported by lpe_serializer and the top level.
package lpe_pkg;

   localparam int MAX_LEDS     = 64;
   localparam int BITS_PER_LED = 24;
   localparam int MAX_RUN      = 64;

   localparam int ADDR_W  = 11;
   localparam int CODE_W  = 16;
   localparam int COLOR_W = 8;
   localparam int LED_W   = 6;
   localparam int CNT_W   = 7;
   localparam int WORD_W  = 3 * COLOR_W;
   localparam int REM_W   = $clog2(MAX_RUN);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHTNESS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_CODE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_CODE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LED_COUNT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_SLOTS = 3'd4;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_LATCH = 1'b1;

   localparam logic [COLOR_W-1:0] BRIGHTNESS_RST  = 8'd0;
   localparam logic [CODE_W-1:0]  ONE_CODE_RST    = 16'd17;
   localparam logic [CODE_W-1:0]  ZERO_CODE_RST   = 16'd9;
   localparam logic [CNT_W-1:0]   LED_COUNT_RST   = 7'd60;
   localparam logic [CNT_W-1:0]   RESET_SLOTS_RST = 7'd42;

   typedef struct packed {
      logic               cmd;
      logic [LED_W-1:0]   led_index;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } req_payload_type;

   typedef struct packed {
      logic [ADDR_W-1:0] slot_address;
      logic [CODE_W-1:0] pulse_code;
      logic              last;
   } rsp_payload_type;

   // prepared work for one transaction, handed to the serializer
   typedef struct packed {
      logic              cmd;
      logic [ADDR_W-1:0] base;
      logic [WORD_W-1:0] word;
      logic [REM_W-1:0]  rem;
   } lpe_item_type;

   typedef struct packed {
      logic [CODE_W-1:0] one_code;
      logic [CODE_W-1:0] zero_code;
   } lpe_codes_type;

   // (c * b) >> 8 when b is nonzero, c unchanged otherwise
   function automatic logic [COLOR_W-1:0] scale_color(input logic [COLOR_W-1:0] c,
                                                       input logic [COLOR_W-1:0] b);
      logic [2*COLOR_W-1:0] prod;
      prod = (2*COLOR_W)'(c) * (2*COLOR_W)'(b);
      if (b != '0) begin
         return prod[2*COLOR_W-1:COLOR_W];
      end
      return c;
   endfunction

   // n * 24 as shift and add
   function automatic logic [ADDR_W-1:0] times_bits(input logic [CNT_W-1:0] n);
      logic [ADDR_W-1:0] w;
      w = ADDR_W'(n);
      return (w << 4) + (w << 3);
   endfunction

endpackage

/* sv/lpe_serializer.sv */
// Holds one prepared transaction and emits its codes into the result register,
// one per cycle unless rsp_stall holds that register. Depends on lpe_pkg.
module lpe_serializer
   import lpe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  lpe_item_type    item,
   input  lpe_codes_type   codes,
   output logic            busy_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   logic              item_valid_ff, item_valid_in;
   logic              cmd_ff, cmd_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [REM_W-1:0]  rem_ff, rem_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   logic out_load;
   logic item_done;

   assign out_load   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign item_done  = out_load && (rem_ff == '0);
   assign busy_stall = item_valid_ff && !item_done;

   always_comb begin
      item_valid_in = item_valid_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      word_in       = word_ff;
      rem_in        = rem_ff;
      if (load) begin
         item_valid_in = 1'b1;
         cmd_in        = item.cmd;
         addr_in       = item.base;
         word_in       = item.word;
         rem_in        = item.rem;
      end else if (item_done) begin
         item_valid_in = 1'b0;
      end else if (out_load) begin
         // advance to the next code of this transaction
         addr_in = addr_ff + 1'b1;
         word_in = {word_ff[WORD_W-2:0], 1'b0};
         rem_in  = rem_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.slot_address  = addr_ff;
         rsp_data_in.last          = (rem_ff == '0);
         if (cmd_ff == CMD_LATCH) begin
            rsp_data_in.pulse_code = '0;
         end else if (word_ff[WORD_W-1]) begin
            rsp_data_in.pulse_code = codes.one_code;
         end else begin
            rsp_data_in.pulse_code = codes.zero_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      addr_ff     <= addr_in;
      word_ff     <= word_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* sv/led_pixel_pulse_code_encoder.sv */
// Top level of the LED pixel pulse code encoder: configuration registers,
// color scaling and slot address setup. Depends on lpe_pkg, lpe_serializer.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  req     | req_valid/req_stall| req_data: cmd, led_index, red, green, blue
//  rsp     | rsp_valid/rsp_stall| rsp_data: slot_address, pulse_code, last
//  csr     | csr_valid/csr_ready| csr_index, csr_wdata (write only)
//
// A pixel transaction yields 24 codes, one per cycle while rsp_stall is low;
// a latch yields reset_slots codes, at most 64 (none if zero).
// The first code passes the item register, then the result register, to rsp;
// the next request is taken in the cycle the previous one's last code is loaded.
// Reset is synchronous and restores register defaults; csr_ready is always high.
// rsp_stall holds the result register and, through it, the serializer.
module led_pixel_pulse_code_encoder
   import lpe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [COLOR_W-1:0] brightness_ff;
   logic [CODE_W-1:0]  one_code_ff;
   logic [CODE_W-1:0]  zero_code_ff;
   logic [CNT_W-1:0]   led_count_ff;
   logic [CNT_W-1:0]   reset_slots_ff;

   logic               csr_write;
   logic               req_take;
   logic               item_load;
   lpe_item_type       item;
   lpe_codes_type      codes;
   logic [CNT_W-1:0]   leds_sat;
   logic [CNT_W-1:0]   run_len;
   logic [CNT_W-1:0]   run_last;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff  <= BRIGHTNESS_RST;
         one_code_ff    <= ONE_CODE_RST;
         zero_code_ff   <= ZERO_CODE_RST;
         led_count_ff   <= LED_COUNT_RST;
         reset_slots_ff <= RESET_SLOTS_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BRIGHTNESS:  brightness_ff  <= csr_wdata[COLOR_W-1:0];
            CSR_ONE_CODE:    one_code_ff    <= csr_wdata[CODE_W-1:0];
            CSR_ZERO_CODE:   zero_code_ff   <= csr_wdata[CODE_W-1:0];
            CSR_LED_COUNT:   led_count_ff   <= csr_wdata[CNT_W-1:0];
            CSR_RESET_SLOTS: reset_slots_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // saturate chain length and gap length
   assign leds_sat = (led_count_ff > CNT_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) : led_count_ff;
   assign run_len  = (reset_slots_ff > CNT_W'(MAX_RUN)) ? CNT_W'(MAX_RUN) : reset_slots_ff;
   assign run_last = run_len - 1'b1;

   always_comb begin
      item.cmd = req_data.cmd;
      if (req_data.cmd == CMD_LATCH) begin
         item.base = times_bits(leds_sat);
         item.word = '0;
         item.rem  = run_last[REM_W-1:0];
      end else begin
         item.base = times_bits(CNT_W'(req_data.led_index));
         item.word = {scale_color(req_data.green, brightness_ff),
                      scale_color(req_data.red, brightness_ff),
                      scale_color(req_data.blue, brightness_ff)};
         item.rem  = REM_W'(BITS_PER_LED - 1);
      end
   end

   // drop a latch with an empty gap
   assign req_take  = req_valid && !req_stall;
   assign item_load = req_take && !((req_data.cmd == CMD_LATCH) && (run_len == '0));

   assign codes.one_code  = one_code_ff;
   assign codes.zero_code = zero_code_ff;

   lpe_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load       (item_load),
      .item       (item),
      .codes      (codes),
      .busy_stall (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

`ifndef ASSERT_OFF
   // a code that is taken and is not the last of its run is followed at once by more
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.last) |=> rsp_valid)
      else $error("result run broken before its last code");

   a_addr_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.last) |=>
      (rsp_data.slot_address == $past(rsp_data.slot_address) + 1'b1))
      else $error("slot address did not advance by one within a run");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !req_stall))
      else $error("block not empty after reset");
`endif

endmodule

/* test/lpe_checker.sv */
// Checker for the LED pixel pulse code encoder: watches the req, rsp and csr
// channels, predicts the pulse codes of each transaction and compares them.
// Depends on lpe_pkg.
`timescale 1ns / 1ps

module lpe_checker
   import lpe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_payload_type       req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_payload_type       rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_codes,
   output int                    checked_codes
);

   // shadow copy of the configuration registers
   logic [COLOR_W-1:0] brightness_q;
   logic [CODE_W-1:0]  one_code_q;
   logic [CODE_W-1:0]  zero_code_q;
   logic [CNT_W-1:0]   led_count_q;
   logic [CNT_W-1:0]   reset_slots_q;

   rsp_payload_type    code_queue[$];

   initial begin
      fail_count    = 0;
      pending_codes = 0;
      checked_codes = 0;
   end

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("%0t mismatch %0d: %s", $realtime, fail_count, msg);
   endtask

   function automatic logic [COLOR_W-1:0] dim_channel(input logic [COLOR_W-1:0] c);
      logic [2*COLOR_W-1:0] prod;
      prod = (2*COLOR_W)'(c) * (2*COLOR_W)'(brightness_q);
      if (brightness_q == '0) begin
         return c;
      end
      return prod[2*COLOR_W-1:COLOR_W];
   endfunction

   // push the codes one accepted transaction must produce
   task automatic expand_command(input req_payload_type item);
      logic [WORD_W-1:0] bits;
      logic [ADDR_W-1:0] base;
      rsp_payload_type   code;
      int                leds;
      int                run;
      int                k;
      if (item.cmd == CMD_PIXEL) begin
         bits = {dim_channel(item.green), dim_channel(item.red), dim_channel(item.blue)};
         base = ADDR_W'(int'(item.led_index) * BITS_PER_LED);
         for (k = 0; k < BITS_PER_LED; k++) begin
            code.slot_address = base + ADDR_W'(k);
            code.pulse_code   = bits[BITS_PER_LED-1-k] ? one_code_q : zero_code_q;
            code.last         = (k == BITS_PER_LED - 1);
            code_queue.push_back(code);
         end
      end else begin
         // clamp chain length and gap length; color fields do not matter here
         leds = (int'(led_count_q) > MAX_LEDS) ? MAX_LEDS : int'(led_count_q);
         run  = (int'(reset_slots_q) > MAX_RUN) ? MAX_RUN : int'(reset_slots_q);
         base = ADDR_W'(leds * BITS_PER_LED);
         for (k = 0; k < run; k++) begin
            code.slot_address = base + ADDR_W'(k);
            code.pulse_code   = '0;
            code.last         = (k == run - 1);
            code_queue.push_back(code);
         end
      end
   endtask

   task automatic compare_code(input rsp_payload_type got);
      rsp_payload_type want;
      if (code_queue.size() == 0) begin
         report_mismatch($sformatf("code 0x%04h at slot %0d with nothing expected",
                                   got.pulse_code, got.slot_address));
         return;
      end
      want = code_queue.pop_front();
      checked_codes++;
      if (got.slot_address !== want.slot_address) begin
         report_mismatch($sformatf("slot_address %0d, expected %0d",
                                   got.slot_address, want.slot_address));
      end
      if (got.pulse_code !== want.pulse_code) begin
         report_mismatch($sformatf("pulse_code 0x%04h at slot %0d, expected 0x%04h",
                                   got.pulse_code, want.slot_address, want.pulse_code));
      end
      if (got.last !== want.last) begin
         report_mismatch($sformatf("last %b at slot %0d, expected %b",
                                   got.last, want.slot_address, want.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         brightness_q  <= BRIGHTNESS_RST;
         one_code_q    <= ONE_CODE_RST;
         zero_code_q   <= ZERO_CODE_RST;
         led_count_q   <= LED_COUNT_RST;
         reset_slots_q <= RESET_SLOTS_RST;
         code_queue.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            compare_code(rsp_data);
         end
         if (req_valid && !req_stall) begin
            expand_command(req_data);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BRIGHTNESS:  brightness_q  <= csr_wdata[COLOR_W-1:0];
               CSR_ONE_CODE:    one_code_q    <= csr_wdata[CODE_W-1:0];
               CSR_ZERO_CODE:   zero_code_q   <= csr_wdata[CODE_W-1:0];
               CSR_LED_COUNT:   led_count_q   <= csr_wdata[CNT_W-1:0];
               CSR_RESET_SLOTS: reset_slots_q <= csr_wdata[CNT_W-1:0];
               default: ;
            endcase
         end
      end
      pending_codes <= code_queue.size();
   end

endmodule

/* test/tb_led_pixel_pulse_code_encoder.sv */
// Testbench top for the LED pixel pulse code encoder: clock, reset, stimulus
// and register settings, random stalls, verdict. Depends on lpe_pkg,
// lpe_checker and led_pixel_pulse_code_encoder.
`timescale 1ns / 1ps

module tb_led_pixel_pulse_code_encoder;
   import lpe_pkg::*;

   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 40;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 25;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_payload_type       req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count;
   int pending_codes;
   int checked_codes;
   int cycle_count = 0;
   int pixels_sent = 0;
   int latches_sent = 0;
   int settings_applied = 0;
   bit no_idle = 1'b0;
   bit hold_request = 1'b0;

   led_pixel_pulse_code_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lpe_checker check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_codes (pending_codes),
      .checked_codes (checked_codes)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d codes outstanding", cycle_count, pending_codes);
         $display("[led_pixel_pulse_code_encoder] ERROR");
         $finish;
      end
   end

   // receiver: random stall runs, one long hold-off on request
   initial begin
      int run;
      int held;
      bit level;
      run   = 0;
      level = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++) begin
               @(posedge clock);
            end
            rsp_stall <= 1'b0;
            run = 0;
         end else if (no_idle) begin
            rsp_stall <= 1'b0;
         end else begin
            if (run == 0) begin
               case ($urandom_range(0, 99)) inside
                  [0:59]:  begin level = 1'b0; run = $urandom_range(1, 8); end
                  [60:91]: begin level = 1'b1; run = $urandom_range(1, 3); end
                  default: begin level = 1'b1; run = $urandom_range(10, 40); end
               endcase
            end
            rsp_stall <= level;
            run--;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 50);
   endfunction

   function automatic req_payload_type make_command(input logic cmd,
                                                    input logic [LED_W-1:0] led,
                                                    input logic [COLOR_W-1:0] r,
                                                    input logic [COLOR_W-1:0] g,
                                                    input logic [COLOR_W-1:0] b);
      req_payload_type item;
      item.cmd       = cmd;
      item.led_index = led;
      item.red       = r;
      item.green     = g;
      item.blue      = b;
      return item;
   endfunction

   // offer one transaction and hold it until taken; valid stays up for a gap of 0
   task automatic send_command(input req_payload_type item);
      int gap;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      if (item.cmd == CMD_PIXEL) begin
         pixels_sent++;
      end else begin
         latches_sent++;
      end
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drop valid, wait for every expected code, then let the block go quiet
   task automatic finish_phase();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_codes != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_setting(input logic [COLOR_W-1:0] b,
                                input logic [CODE_W-1:0] one,
                                input logic [CODE_W-1:0] zero,
                                input logic [CNT_W-1:0] leds,
                                input logic [CNT_W-1:0] slots);
      write_register(CSR_BRIGHTNESS, CSR_DATA_W'(b));
      write_register(CSR_ONE_CODE, one);
      write_register(CSR_ZERO_CODE, zero);
      write_register(CSR_LED_COUNT, CSR_DATA_W'(leds));
      write_register(CSR_RESET_SLOTS, CSR_DATA_W'(slots));
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   task automatic random_setting();
      logic [COLOR_W-1:0] b;
      logic [CNT_W-1:0]   leds;
      logic [CNT_W-1:0]   slots;
      case ($urandom_range(0, 99)) inside
         [0:24]:  b = '0;
         [25:39]: b = '1;
         default: b = COLOR_W'($urandom_range(1, 254));
      endcase
      case ($urandom_range(0, 99)) inside
         [0:9]:   leds = '0;
         [10:19]: leds = CNT_W'($urandom_range(MAX_LEDS + 1, 127));
         default: leds = CNT_W'($urandom_range(1, MAX_LEDS));
      endcase
      // mostly short gaps keep the run quick; a few empty, full or oversized
      case ($urandom_range(0, 99)) inside
         [0:9]:   slots = '0;
         [10:14]: slots = CNT_W'(MAX_RUN);
         [15:19]: slots = CNT_W'($urandom_range(MAX_RUN + 1, 127));
         default: slots = CNT_W'($urandom_range(1, 12));
      endcase
      apply_setting(b, CODE_W'($urandom_range(0, 65535)), CODE_W'($urandom_range(0, 65535)),
                    leds, slots);
   endtask

   task automatic random_phase(input int count, input bit with_hold);
      int i;
      for (i = 0; i < count; i++) begin
         if (with_hold && i == 4) begin
            hold_request = 1'b1;
         end
         if ($urandom_range(0, 99) < 20) begin
            send_command(make_command(CMD_LATCH, LED_W'($urandom_range(0, 63)),
                                      COLOR_W'($urandom_range(0, 255)),
                                      COLOR_W'($urandom_range(0, 255)),
                                      COLOR_W'($urandom_range(0, 255))));
         end else begin
            send_command(make_command(CMD_PIXEL, LED_W'($urandom_range(0, 63)),
                                      COLOR_W'($urandom_range(0, 255)),
                                      COLOR_W'($urandom_range(0, 255)),
                                      COLOR_W'($urandom_range(0, 255))));
         end
      end
      finish_phase();
   endtask

   initial begin
      int p;
      int i;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults; pixels inside the chain and pixels past its end
      send_command(make_command(CMD_PIXEL, 6'd0, 8'h00, 8'h00, 8'h00));
      send_command(make_command(CMD_PIXEL, 6'd63, 8'hFF, 8'hFF, 8'hFF));
      send_command(make_command(CMD_PIXEL, 6'd21, 8'hA5, 8'h3C, 8'h81));
      send_command(make_command(CMD_LATCH, 6'd63, 8'hFF, 8'hFF, 8'hFF));
      send_command(make_command(CMD_PIXEL, 6'd61, 8'h01, 8'h80, 8'h7E));
      finish_phase();

      apply_setting(8'hFF, 16'hFFFF, 16'h0000, 7'd64, 7'd64);
      send_command(make_command(CMD_PIXEL, 6'd63, 8'hFF, 8'hFF, 8'hFF));
      send_command(make_command(CMD_PIXEL, 6'd0, 8'h80, 8'h01, 8'hFE));
      send_command(make_command(CMD_LATCH, 6'd0, 8'h00, 8'h00, 8'h00));
      finish_phase();

      // brightness 1 scales every byte down to zero
      apply_setting(8'h01, 16'h0000, 16'hFFFF, 7'd1, 7'd1);
      send_command(make_command(CMD_PIXEL, 6'd40, 8'hFF, 8'hFF, 8'hFF));
      send_command(make_command(CMD_LATCH, 6'd0, 8'h00, 8'h00, 8'h00));
      send_command(make_command(CMD_LATCH, 6'd42, 8'h5A, 8'hC3, 8'h96));
      finish_phase();

      // writes to unused indexes must change nothing; empty chain, empty gap
      for (i = int'(CSR_RESET_SLOTS) + 1; i < (1 << CSR_IDX_W); i++) begin
         write_register(CSR_IDX_W'(i), 16'hFFFF);
      end
      apply_setting(8'h80, 16'hAAAA, 16'h5555, 7'd0, 7'd0);
      send_command(make_command(CMD_LATCH, 6'd0, 8'h00, 8'h00, 8'h00));
      send_command(make_command(CMD_PIXEL, 6'd1, 8'hC3, 8'h3C, 8'h99));
      send_command(make_command(CMD_LATCH, 6'd63, 8'hFF, 8'hFF, 8'hFF));
      finish_phase();

      // oversized chain and gap clamp to the maximum
      apply_setting(8'h00, 16'h1234, 16'hEDCB, 7'd127, 7'd100);
      send_command(make_command(CMD_LATCH, 6'd0, 8'h00, 8'h00, 8'h00));
      send_command(make_command(CMD_PIXEL, 6'd63, 8'h00, 8'hFF, 8'h00));
      finish_phase();

      apply_setting(8'hFE, 16'h8001, 16'h7FFE, 7'd65, 7'd65);
      send_command(make_command(CMD_LATCH, 6'd0, 8'h00, 8'h00, 8'h00));
      send_command(make_command(CMD_PIXEL, 6'd32, 8'hFF, 8'h7F, 8'h01));
      finish_phase();

      for (p = 0; p < RANDOM_PHASES; p++) begin
         random_setting();
         no_idle = (p == 2);
         random_phase(PHASE_ITEMS, p == 4);
         no_idle = 1'b0;
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Summary: %0d pixel and %0d latch transactions under %0d register settings,",
               pixels_sent, latches_sent, settings_applied);
      $display("         %0d pulse codes compared, %0d mismatches", checked_codes, fail_count);
      if (fail_count == 0) begin
         $display("[led_pixel_pulse_code_encoder] OK");
      end else begin
         $display("[led_pixel_pulse_code_encoder] ERROR");
      end
      $finish;
   end

endmodule
